// ----- rtl/dsu_pkg.sv -----
// Shared types, constants and codes for the disjoint-set engine.
package dsu_pkg;

    localparam int MAX_ELEMS = 1024;
    localparam int IDX_W     = 10;
    localparam int SIZE_W    = 11;

    localparam logic [1:0] ACT_FIND  = 2'd0;
    localparam logic [1:0] ACT_UNION = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]       action;
        logic [IDX_W-1:0] elem_a;
        logic [IDX_W-1:0] elem_b;
    } req_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]  root;
        logic [SIZE_W-1:0] set_size;
        logic              merged;
        logic              bad_index;
    } rsp_item_t;

    typedef enum logic [1:0] {
        RES_FIND  = 2'd0,
        RES_UNION = 2'd1,
        RES_OK    = 2'd2,
        RES_BAD   = 2'd3
    } res_sel_t;

    typedef struct packed {
        logic     item_load;
        logic     walk_start;
        logic     sel_b;
        logic     walk_step;
        logic     comp_start;
        logic     comp_step;
        logic     save_ra;
        logic     size_rd_ra;
        logic     sa_load;
        logic     link_en;
        logic     res_load;
        res_sel_t res_sel;
        logic     out_load;
        logic     sweep_clr;
        logic     sweep_step;
        logic     sweep_all;
    } dsu_cmd_t;

    typedef struct packed {
        logic [1:0] req_action;
        logic       req_bad;
        logic       walk_hit;
        logic       comp_done;
        logic       sweep_done;
    } dsu_stat_t;

endpackage

// ----- rtl/disjoint_set_union_find.sv -----
// Top level of the disjoint-set engine: controller plus datapath.
//
//  channel | signals                           | transaction
//  --------+-----------------------------------+----------------------------------
//  req     | req_valid, req_ready, req_item    | one find, union or clear action
//  rsp     | rsp_valid, rsp_ready, rsp_item    | one result per action
//  cfg     | cfg_valid, cfg_ready, cfg_data    | write of active_count
//
// A find walks the path from its element to the root and then compresses it; a union does
// both for each of its two elements and then links the two roots; each walk steps through
// the single read port of the link memory (one step a cycle).
// A clear resets the first min(active_count, 1024) entries, one entry written per cycle.
// After reset a clearing pass over all 1024 entries runs before req_ready rises; cfg is always taken.
// The finished result sits in an output register, so the next action is taken while it waits.
module disjoint_set_union_find
    import dsu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  req_item_t         req_item,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output rsp_item_t         rsp_item,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [SIZE_W-1:0] cfg_data
);

    dsu_cmd_t  cmd;
    dsu_stat_t stat;

    assign cfg_ready = 1'b1;

    dsu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    dsu_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_item  (req_item),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_item  (rsp_item)
    );

endmodule

// ----- rtl/dsu_dp.sv -----
// Datapath: link and size memories, walk pointers, sweep counter and result registers.
module dsu_dp
    import dsu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  req_item_t         req_item,
    input  logic              cfg_valid,
    input  logic [SIZE_W-1:0] cfg_data,
    input  dsu_cmd_t          cmd,
    output dsu_stat_t         stat,
    output rsp_item_t         rsp_item
);

    logic [IDX_W-1:0]  parent_mem [MAX_ELEMS];
    logic [SIZE_W-1:0] size_mem   [MAX_ELEMS];

    logic [IDX_W-1:0]  p_rdata_reg;
    logic [SIZE_W-1:0] s_rdata_reg;
    logic [IDX_W-1:0]  p_raddr;
    logic [IDX_W-1:0]  s_raddr;
    logic              p_we;
    logic [IDX_W-1:0]  p_waddr;
    logic [IDX_W-1:0]  p_wdata;
    logic              s_we;
    logic [IDX_W-1:0]  s_waddr;
    logic [SIZE_W-1:0] s_wdata;

    logic [SIZE_W-1:0] active_reg;
    logic [SIZE_W:0]   cnt_reg;
    logic [SIZE_W:0]   cnt_next;
    logic [IDX_W-1:0]  a_reg;
    logic [IDX_W-1:0]  b_reg;
    logic [IDX_W-1:0]  cur_reg;
    logic [IDX_W-1:0]  cur_next;
    logic [IDX_W-1:0]  root_reg;
    logic [IDX_W-1:0]  ra_reg;
    logic [SIZE_W-1:0] sa_reg;
    rsp_item_t         res_reg;
    rsp_item_t         res_next;
    rsp_item_t         out_reg;

    logic [SIZE_W-1:0] eff_n;
    logic [SIZE_W:0]   sweep_limit;
    logic [IDX_W-1:0]  start_idx;
    logic              same_root;
    logic              a_is_lo;
    logic [IDX_W-1:0]  lo_idx;
    logic [IDX_W-1:0]  hi_idx;
    logic [SIZE_W:0]   sum_raw;
    logic [SIZE_W-1:0] sum_sat;

    assign eff_n = (active_reg > SIZE_W'(MAX_ELEMS)) ? SIZE_W'(MAX_ELEMS) : active_reg;
    assign sweep_limit = cmd.sweep_all ? (SIZE_W+1)'(MAX_ELEMS) : {1'b0, eff_n};
    assign start_idx = cmd.sel_b ? b_reg : a_reg;

    // union decision: ra/sa from first walk, rb/sb live from second walk
    assign same_root = (ra_reg == root_reg);
    assign a_is_lo   = !(sa_reg > s_rdata_reg);
    assign lo_idx    = a_is_lo ? ra_reg : root_reg;
    assign hi_idx    = a_is_lo ? root_reg : ra_reg;
    assign sum_raw   = {1'b0, sa_reg} + {1'b0, s_rdata_reg};
    assign sum_sat   = (sum_raw > (SIZE_W+1)'(MAX_ELEMS)) ? SIZE_W'(MAX_ELEMS)
                                                          : sum_raw[SIZE_W-1:0];

    always_comb
    begin
        logic bad_a;
        logic bad_b;
        bad_a = ({1'b0, req_item.elem_a} >= eff_n);
        bad_b = ({1'b0, req_item.elem_b} >= eff_n);
        stat.req_action = req_item.action;
        case (req_item.action)
            ACT_FIND:  stat.req_bad = bad_a;
            ACT_UNION: stat.req_bad = bad_a || bad_b;
            default:   stat.req_bad = 1'b0;
        endcase
        stat.walk_hit   = (p_rdata_reg == cur_reg);
        stat.comp_done  = (cur_reg == root_reg);
        stat.sweep_done = (cnt_reg >= sweep_limit);
    end

    always_comb
    begin
        p_raddr  = cur_reg;
        cur_next = cur_reg;
        p_we     = 1'b0;
        p_waddr  = cur_reg;
        p_wdata  = root_reg;
        s_we     = 1'b0;
        s_waddr  = hi_idx;
        s_wdata  = sum_sat;
        cnt_next = cnt_reg;
        if (cmd.walk_start || cmd.comp_start)
        begin
            p_raddr  = start_idx;
            cur_next = start_idx;
        end
        else if ((cmd.walk_step && !stat.walk_hit) || (cmd.comp_step && !stat.comp_done))
        begin
            p_raddr  = p_rdata_reg;
            cur_next = p_rdata_reg;
        end
        if (cmd.comp_step && !stat.comp_done)
        begin
            p_we = 1'b1;
        end
        else if (cmd.link_en && !same_root)
        begin
            p_we    = 1'b1;
            p_waddr = lo_idx;
            p_wdata = hi_idx;
            s_we    = 1'b1;
        end
        else if (cmd.sweep_step)
        begin
            p_we     = 1'b1;
            p_waddr  = cnt_reg[IDX_W-1:0];
            p_wdata  = cnt_reg[IDX_W-1:0];
            s_we     = 1'b1;
            s_waddr  = cnt_reg[IDX_W-1:0];
            s_wdata  = SIZE_W'(1);
        end
        if (cmd.sweep_clr)
        begin
            cnt_next = '0;
        end
        else if (cmd.sweep_step)
        begin
            cnt_next = cnt_reg + (SIZE_W+1)'(1);
        end
    end

    assign s_raddr = cmd.size_rd_ra ? ra_reg : root_reg;

    always_comb
    begin
        res_next = '{root: '0, set_size: SIZE_W'(1), merged: 1'b0, bad_index: 1'b0};
        case (cmd.res_sel)
            RES_FIND:
            begin
                res_next.root     = root_reg;
                res_next.set_size = s_rdata_reg;
            end
            RES_UNION:
            begin
                if (same_root)
                begin
                    res_next.root     = ra_reg;
                    res_next.set_size = sa_reg;
                end
                else
                begin
                    res_next.root     = hi_idx;
                    res_next.set_size = sum_sat;
                    res_next.merged   = 1'b1;
                end
            end
            RES_BAD:
            begin
                res_next.bad_index = 1'b1;
            end
            default:
            begin
                res_next.bad_index = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            parent_mem[p_waddr] <= p_wdata;
        end
        p_rdata_reg <= parent_mem[p_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            size_mem[s_waddr] <= s_wdata;
        end
        s_rdata_reg <= size_mem[s_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= SIZE_W'(MAX_ELEMS);
            cnt_reg    <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                active_reg <= cfg_data;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            a_reg   <= req_item.elem_a;
            b_reg   <= req_item.elem_b;
        end
        cur_reg <= cur_next;
        if (cmd.walk_step && stat.walk_hit)
        begin
            root_reg <= cur_reg;
        end
        if (cmd.save_ra)
        begin
            ra_reg <= root_reg;
        end
        if (cmd.sa_load)
        begin
            sa_reg <= s_rdata_reg;
        end
        if (cmd.res_load)
        begin
            res_reg <= res_next;
        end
        if (cmd.out_load)
        begin
            out_reg <= res_reg;
        end
    end

    assign rsp_item = out_reg;

endmodule

// ----- rtl/dsu_ctrl.sv -----
// Controller: sequences walks, compression, linking and clearing sweeps.
module dsu_ctrl
    import dsu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    input  dsu_stat_t stat,
    output dsu_cmd_t  cmd
);

    typedef enum logic [10:0] {
        ST_INIT      = 11'b000_0000_0001,
        ST_IDLE      = 11'b000_0000_0010,
        ST_WALK_PRIME = 11'b000_0000_0100,
        ST_WALK      = 11'b000_0000_1000,
        ST_COMP_PRIME = 11'b000_0001_0000,
        ST_COMP      = 11'b000_0010_0000,
        ST_FIND_SIZE = 11'b000_0100_0000,
        ST_U_SIZE_A  = 11'b000_1000_0000,
        ST_U_SIZE_B  = 11'b001_0000_0000,
        ST_CLEAR     = 11'b010_0000_0000,
        ST_DONE      = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   union_reg;
    logic   union_next;
    logic   second_reg;
    logic   second_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        union_next     = union_reg;
        second_next    = second_reg;
        rsp_valid_next = rsp_valid_reg;
        cmd            = '0;
        cmd.res_sel    = RES_OK;
        cmd.sel_b      = second_reg;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        case (state_reg)
            ST_INIT:
            begin
                cmd.sweep_all = 1'b1;
                if (stat.sweep_done)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.sweep_step = 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.item_load = 1'b1;
                    second_next   = 1'b0;
                    union_next    = (stat.req_action == ACT_UNION);
                    case (stat.req_action)
                        ACT_FIND, ACT_UNION:
                        begin
                            if (stat.req_bad)
                            begin
                                cmd.res_load = 1'b1;
                                cmd.res_sel  = RES_BAD;
                                state_next   = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_WALK_PRIME;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            cmd.sweep_clr = 1'b1;
                            state_next    = ST_CLEAR;
                        end
                        default:
                        begin
                            cmd.res_load = 1'b1;
                            state_next   = ST_DONE;
                        end
                    endcase
                end
            end
            ST_WALK_PRIME:
            begin
                cmd.walk_start = 1'b1;
                state_next     = ST_WALK;
            end
            ST_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (stat.walk_hit)
                begin
                    state_next = ST_COMP_PRIME;
                end
            end
            ST_COMP_PRIME:
            begin
                cmd.comp_start = 1'b1;
                state_next     = ST_COMP;
            end
            ST_COMP:
            begin
                cmd.comp_step = 1'b1;
                if (stat.comp_done)
                begin
                    if (!union_reg)
                    begin
                        state_next = ST_FIND_SIZE;
                    end
                    else if (!second_reg)
                    begin
                        cmd.save_ra = 1'b1;
                        second_next = 1'b1;
                        state_next  = ST_WALK_PRIME;
                    end
                    else
                    begin
                        cmd.size_rd_ra = 1'b1;
                        state_next     = ST_U_SIZE_A;
                    end
                end
            end
            ST_FIND_SIZE:
            begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = RES_FIND;
                state_next   = ST_DONE;
            end
            ST_U_SIZE_A:
            begin
                // size of the second root is read while the first is captured
                cmd.sa_load = 1'b1;
                state_next  = ST_U_SIZE_B;
            end
            ST_U_SIZE_B:
            begin
                cmd.link_en  = 1'b1;
                cmd.res_load = 1'b1;
                cmd.res_sel  = RES_UNION;
                state_next   = ST_DONE;
            end
            ST_CLEAR:
            begin
                if (stat.sweep_done)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_DONE;
                end
                else
                begin
                    cmd.sweep_step = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.out_load   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            union_reg     <= 1'b0;
            second_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            union_reg     <= union_next;
            second_reg    <= second_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

// ----- dv/dsu_scoreboard_pkg.sv -----
`timescale 1ns / 1ps
// Scoreboard for the disjoint-set engine: its own copy of the link and size tables.
package dsu_scoreboard_pkg;
    import dsu_pkg::*;

    class dsu_scoreboard;
        logic [IDX_W-1:0]  link_table [MAX_ELEMS];
        logic [SIZE_W-1:0] size_table [MAX_ELEMS];
        logic [SIZE_W-1:0] count_reg;
        rsp_item_t         expected_q [$];
        int unsigned       mismatches;

        function new();
            clear_range(MAX_ELEMS);
            count_reg  = SIZE_W'(MAX_ELEMS);
            mismatches = 0;
        endfunction

        function void set_count(logic [SIZE_W-1:0] value);
            count_reg = value;
        endfunction

        function int unsigned live_count();
            return (count_reg > MAX_ELEMS) ? MAX_ELEMS : count_reg;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void clear_range(int unsigned n);
            for (int unsigned i = 0; i < n && i < MAX_ELEMS; i++)
            begin
                link_table[i] = IDX_W'(i);
                size_table[i] = SIZE_W'(1);
            end
        endfunction

        // Walk to the root, then point every entry on the path straight at it.
        // The step bound only guards termination.
        function logic [IDX_W-1:0] find_root(logic [IDX_W-1:0] start);
            logic [IDX_W-1:0] top;
            logic [IDX_W-1:0] walk;
            logic [IDX_W-1:0] nxt;
            int unsigned      steps;
            top   = start;
            steps = 0;
            while (link_table[top] != top && steps < MAX_ELEMS)
            begin
                top = link_table[top];
                steps++;
            end
            walk  = start;
            steps = 0;
            while (walk != top && steps < MAX_ELEMS)
            begin
                nxt              = link_table[walk];
                link_table[walk] = top;
                walk             = nxt;
                steps++;
            end
            return top;
        endfunction

        function void note_request(req_item_t item);
            rsp_item_t        res;
            int unsigned      n;
            int unsigned      total;
            logic [IDX_W-1:0] ra;
            logic [IDX_W-1:0] rb;
            logic [IDX_W-1:0] lo;
            logic [IDX_W-1:0] hi;
            res          = '0;
            res.set_size = SIZE_W'(1);
            n            = live_count();
            case (item.action)
                ACT_FIND:
                begin
                    if (item.elem_a >= n)
                        res.bad_index = 1'b1;
                    else
                    begin
                        res.root     = find_root(item.elem_a);
                        res.set_size = size_table[res.root];
                    end
                end
                ACT_UNION:
                begin
                    if (item.elem_a >= n || item.elem_b >= n)
                        res.bad_index = 1'b1;
                    else
                    begin
                        ra = find_root(item.elem_a);
                        rb = find_root(item.elem_b);
                        if (ra == rb)
                            res.root = ra;
                        else
                        begin
                            // equal sizes: elem_a's root goes under elem_b's
                            lo = ra;
                            hi = rb;
                            if (size_table[ra] > size_table[rb])
                            begin
                                lo = rb;
                                hi = ra;
                            end
                            link_table[lo] = hi;
                            total = size_table[hi] + size_table[lo];
                            if (total > MAX_ELEMS)
                                total = MAX_ELEMS;
                            size_table[hi] = SIZE_W'(total);
                            res.root       = hi;
                            res.merged     = 1'b1;
                        end
                        res.set_size = size_table[res.root];
                    end
                end
                ACT_CLEAR:
                    clear_range(n);
                default:
                    ;
            endcase
            expected_q.push_back(res);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
            end
        endfunction

        function void check_result(rsp_item_t got);
            rsp_item_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result root %0d size %0d merged %0b bad %0b",
                             $realtime, got.root, got.set_size, got.merged, got.bad_index);
                return;
            end
            want = expected_q.pop_front();
            compare_field("root", want.root, got.root);
            compare_field("set_size", want.set_size, got.set_size);
            compare_field("merged", want.merged, got.merged);
            compare_field("bad_index", want.bad_index, got.bad_index);
        endfunction
    endclass

endpackage

// ----- dv/disjoint_set_union_find_test.sv -----
`timescale 1ns / 1ps
// Top-level testbench for the disjoint-set engine: directed and random actions, random stalls.
module disjoint_set_union_find_test;
    import dsu_pkg::*;
    import dsu_scoreboard_pkg::*;

    localparam logic [1:0] ACT_NONE = 2'd3;   // undefined action, answered but ignored
    localparam int TARGET_ITEMS   = 700;
    localparam int STALL_LIMIT    = 20000;
    localparam int DRAIN_CYCLES   = 64;
    localparam int HOLD_AT        = 150;
    localparam int HOLD_CYCLES    = 400;
    localparam int CALM_TX_FROM   = 300;
    localparam int CALM_TX_TO     = 400;
    localparam int CALM_RX_FROM   = 320;
    localparam int CALM_RX_TO     = 440;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              req_valid;
    logic              req_ready;
    req_item_t         req_item;
    logic              rsp_valid;
    logic              rsp_ready = 1'b0;
    rsp_item_t         rsp_item;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [SIZE_W-1:0] cfg_data;

    dsu_scoreboard board;
    int unsigned   sent_total    = 0;
    int unsigned   results_total = 0;
    int unsigned   hold_left     = 0;
    bit            hold_done     = 1'b0;
    int unsigned   quiet_cycles  = 0;

    disjoint_set_union_find DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_item  (rsp_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // offer one action and hold it until the transaction completes
    task automatic issue(input logic [1:0] act, input int unsigned a, input int unsigned b);
        req_item_t item;
        item.action = act;
        item.elem_a = IDX_W'(a);
        item.elem_b = IDX_W'(b);
        while (!(sent_total >= CALM_TX_FROM && sent_total < CALM_TX_TO)
               && $urandom_range(0, 99) < 14)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= item;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        board.note_request(item);
        sent_total++;
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // register writes only go in once the engine has gone idle
    task automatic write_count(input logic [SIZE_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        board.set_count(value);
    endtask

    // result side: random stalls, one long hold-off, one calm stretch
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                board.check_result(rsp_item);
                results_total++;
            end
            // hold off only while the sender is offering, so the engine backs up
            if (!hold_done && results_total >= HOLD_AT && req_valid)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else if (results_total >= CALM_RX_FROM && results_total < CALM_RX_TO)
                rsp_ready <= 1'b1;
            else
                rsp_ready <= ($urandom_range(0, 99) >= 14);
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        int unsigned n;
        int unsigned live;
        int unsigned span;
        int unsigned roll;
        int unsigned a;
        int unsigned b;
        int unsigned out_idx;

        board = new();
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req_item  <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // full table after reset: extremes, merges, equal-size tie, same-set union
        issue(ACT_FIND, 0, 0);
        issue(ACT_FIND, 1023, 1023);
        issue(ACT_UNION, 0, 1023);
        issue(ACT_UNION, 1023, 5);
        issue(ACT_UNION, 5, 0);
        issue(ACT_FIND, 0, 1023);
        issue(ACT_NONE, 1023, 1023);
        issue(ACT_UNION, 3, 100);
        issue(ACT_UNION, 200, 100);

        // small count: bad indices, walks through stale links, partial clear
        write_count(SIZE_W'(4));
        issue(ACT_FIND, 4, 0);
        issue(ACT_UNION, 1, 4);
        issue(ACT_UNION, 4, 1);
        issue(ACT_FIND, 3, 0);
        issue(ACT_UNION, 0, 2);
        issue(ACT_CLEAR, 0, 0);

        write_count('0);
        issue(ACT_FIND, 0, 0);
        issue(ACT_UNION, 0, 0);
        issue(ACT_CLEAR, 1023, 1023);

        // count above the table size is clipped; stale sizes carry on
        write_count('1);
        issue(ACT_FIND, 200, 0);
        issue(ACT_FIND, 1023, 0);
        issue(ACT_UNION, 1023, 100);
        issue(ACT_CLEAR, 0, 0);

        while (sent_total < TARGET_ITEMS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 10)
                n = MAX_ELEMS;
            else if (roll < 15)
                n = $urandom_range(MAX_ELEMS + 1, 2047);
            else if (roll < 18)
                n = 0;
            else if (roll < 21)
                n = 1;
            else if (roll < 36)
                n = $urandom_range(49, MAX_ELEMS - 1);
            else
                n = $urandom_range(2, 48);
            write_count(SIZE_W'(n));
            live = (n > MAX_ELEMS) ? MAX_ELEMS : n;
            span = $urandom_range(40, 110);
            repeat (span)
            begin
                if (live == 0)
                begin
                    a = $urandom_range(0, MAX_ELEMS - 1);
                    b = $urandom_range(0, MAX_ELEMS - 1);
                end
                else
                begin
                    a = $urandom_range(0, live - 1);
                    b = $urandom_range(0, live - 1);
                end
                roll = $urandom_range(0, 99);
                if (roll < 40)
                    issue(ACT_FIND, a, b);
                else if (roll < 85)
                    issue(ACT_UNION, a, b);
                else if (roll < 89)
                    issue(ACT_CLEAR, a, b);
                else if (roll < 92)
                    issue(ACT_NONE, $urandom_range(0, MAX_ELEMS - 1),
                          $urandom_range(0, MAX_ELEMS - 1));
                else if (live >= MAX_ELEMS)
                    issue(ACT_FIND, a, b);
                else
                begin
                    out_idx = $urandom_range(live, MAX_ELEMS - 1);
                    case ($urandom_range(0, 2))
                        0:       issue(ACT_FIND, out_idx, b);
                        1:       issue(ACT_UNION, out_idx, b);
                        default: issue(ACT_UNION, a, out_idx);
                    endcase
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
